/* sv/dfpx_pkg.sv */
// Shared types and constants for the delimited frame parser.
package dfpx_pkg;

   localparam int unsigned MAX_PAYLOAD = 1024;
   localparam int unsigned CSR_AW      = 4;
   localparam int unsigned CSR_DW      = 32;
   localparam int unsigned LEN_W       = 11;

   localparam logic [7:0]       START_RESET   = 8'h5B;
   localparam logic [7:0]       END_RESET     = 8'h5D;
   localparam logic [3:0]       ACK_NIB_RESET = 4'hA;
   localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(MAX_PAYLOAD);
   localparam logic [LEN_W-1:0] LEN_SAT       = {LEN_W{1'b1}};

   typedef enum logic [1:0] {
      CSR_START   = 2'd0,
      CSR_END     = 2'd1,
      CSR_ACK_NIB = 2'd2,
      CSR_MAX_LEN = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_FIRST   = 3'd1,
      PH_PARAM   = 3'd2,
      PH_LEN     = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_XOR     = 3'd5,
      PH_END     = 3'd6,
      PH_ACK     = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      EV_PAYLOAD  = 3'd0,
      EV_REQ_OK   = 3'd1,
      EV_REQ_CSUM = 3'd2,
      EV_END_ERR  = 3'd3,
      EV_LEN_ERR  = 3'd4,
      EV_ACK_OK   = 3'd5,
      EV_ACK_ERR  = 3'd6
   } event_type;

   typedef struct packed {
      logic [7:0]       start_delimiter;
      logic [7:0]       end_delimiter;
      logic [3:0]       ack_type_nibble;
      logic [LEN_W-1:0] max_payload_length;
   } cfg_type;

   typedef struct packed {
      logic [2:0]       event_res;
      logic [7:0]       data_byte;
      logic [7:0]       frame_type;
      logic [7:0]       frame_param;
      logic [LEN_W-1:0] payload_length;
      logic             last;
   } rsp_type;

endpackage

/* sv/dfpx_req_if.sv */
// Input byte channel.
interface dfpx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

/* sv/dfpx_rsp_if.sv */
// Result channel.
interface dfpx_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [7:0]  data_byte;
   logic [7:0]  frame_type;
   logic [7:0]  frame_param;
   logic [10:0] payload_length;
   logic        last;

   modport source (output valid, output event_res, output data_byte, output frame_type,
                   output frame_param, output payload_length, output last, input ready);
   modport sink (input valid, input event_res, input data_byte, input frame_type,
                 input frame_param, input payload_length, input last, output ready);
endinterface

/* sv/dfpx_csr.sv */
// APB configuration registers.
module dfpx_csr import dfpx_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   logic [7:0]       start_ff, start_in;
   logic [7:0]       end_ff, end_in;
   logic [3:0]       ack_nib_ff, ack_nib_in;
   logic [LEN_W-1:0] max_len_ff, max_len_in;
   logic             wr_en;
   csr_idx_type      idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = csr_idx_type'(paddr[CSR_AW-1:2]);

   always_comb begin
      start_in   = start_ff;
      end_in     = end_ff;
      ack_nib_in = ack_nib_ff;
      max_len_in = max_len_ff;
      if (wr_en) begin
         unique case (idx)
            CSR_START:   start_in   = pwdata[7:0];
            CSR_END:     end_in     = pwdata[7:0];
            CSR_ACK_NIB: ack_nib_in = pwdata[3:0];
            CSR_MAX_LEN: max_len_in = pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         CSR_START:   prdata = {{(CSR_DW-8){1'b0}}, start_ff};
         CSR_END:     prdata = {{(CSR_DW-8){1'b0}}, end_ff};
         CSR_ACK_NIB: prdata = {{(CSR_DW-4){1'b0}}, ack_nib_ff};
         CSR_MAX_LEN: prdata = {{(CSR_DW-LEN_W){1'b0}}, max_len_ff};
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= START_RESET;
         end_ff     <= END_RESET;
         ack_nib_ff <= ACK_NIB_RESET;
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         start_ff   <= start_in;
         end_ff     <= end_in;
         ack_nib_ff <= ack_nib_in;
         max_len_ff <= max_len_in;
      end
   end

   assign cfg = '{start_delimiter:    start_ff,
                  end_delimiter:      end_ff,
                  ack_type_nibble:    ack_nib_ff,
                  max_payload_length: max_len_ff};

endmodule

/* sv/dfpx_core.sv */
// Frame state machine, checksum and per-byte result decode.
module dfpx_core import dfpx_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       in_fire,
   input  logic [7:0] rx_byte,
   output logic       res_valid,
   output rsp_type    res
);

   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       xor_ff, xor_in;
   logic [7:0]       type_ff, type_in;
   logic [7:0]       param_ff, param_in;
   logic [15:0]      len_ff, len_in;
   logic [7:0]       code_lo_ff, code_lo_in;
   logic             csum_ok_ff, csum_ok_in;

   logic [LEN_W-1:0] limit;
   logic [15:0]      len_full;
   logic             len_too_long;
   logic [LEN_W-1:0] cnt_inc;
   logic             payload_done;
   logic             is_start, is_end, is_ack, xor_match;
   logic             len_low_byte;
   logic [LEN_W-1:0] len_sat;

   assign limit        = (cfg.max_payload_length > LEN_W'(MAX_PAYLOAD)) ?
                         LEN_W'(MAX_PAYLOAD) : cfg.max_payload_length;
   assign len_full     = {len_ff[15:8], rx_byte};
   assign len_too_long = len_full > {{(16-LEN_W){1'b0}}, limit};
   assign cnt_inc      = cnt_ff + LEN_W'(1);
   assign payload_done = {{(16-LEN_W){1'b0}}, cnt_inc} >= len_ff;
   assign is_start     = rx_byte == cfg.start_delimiter;
   assign is_end       = rx_byte == cfg.end_delimiter;
   assign is_ack       = rx_byte[7:4] == cfg.ack_type_nibble;
   assign xor_match    = rx_byte == xor_ff;
   assign len_low_byte = cnt_ff != '0;

   // status length field saturates at the 11-bit maximum
   assign len_sat = (len_ff > {{(16-LEN_W){1'b0}}, LEN_SAT}) ? LEN_SAT : len_ff[LEN_W-1:0];

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (in_fire) begin
         unique case (phase_ff)
            PH_HUNT:    if (is_start) phase_in = PH_FIRST;
            PH_FIRST:   phase_in = is_ack ? PH_ACK : PH_PARAM;
            PH_PARAM:   phase_in = PH_LEN;
            PH_LEN: begin
               if (len_low_byte) begin
                  if (len_too_long)        phase_in = PH_HUNT;
                  else if (len_full == '0) phase_in = PH_XOR;
                  else                     phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: if (payload_done) phase_in = PH_XOR;
            PH_XOR:     phase_in = PH_END;
            PH_END:     phase_in = PH_HUNT;
            PH_ACK:     if (cnt_ff == LEN_W'(3)) phase_in = PH_HUNT;
            default:    phase_in = PH_HUNT;
         endcase
      end
   end

   // datapath and result
   always_comb begin
      cnt_in     = cnt_ff;
      xor_in     = xor_ff;
      type_in    = type_ff;
      param_in   = param_ff;
      len_in     = len_ff;
      code_lo_in = code_lo_ff;
      csum_ok_in = csum_ok_ff;
      res_valid  = 1'b0;
      res        = '{event_res:      EV_PAYLOAD,
                     data_byte:      8'h00,
                     frame_type:     type_ff,
                     frame_param:    param_ff,
                     payload_length: '0,
                     last:           1'b0};
      if (in_fire) begin
         unique case (phase_ff)
            PH_HUNT: ;
            PH_FIRST: begin
               type_in = rx_byte;
               xor_in  = rx_byte;
               cnt_in  = '0;
            end
            PH_PARAM: begin
               param_in = rx_byte;
               xor_in   = xor_ff ^ rx_byte;
               cnt_in   = '0;
            end
            PH_LEN: begin
               xor_in = xor_ff ^ rx_byte;
               if (!len_low_byte) begin
                  len_in = {rx_byte, 8'h00};
                  cnt_in = LEN_W'(1);
               end else begin
                  len_in = len_full;
                  cnt_in = '0;
                  if (len_too_long) begin
                     res_valid          = 1'b1;
                     res.event_res      = EV_LEN_ERR;
                     res.last           = 1'b1;
                     res.payload_length = (len_full > {{(16-LEN_W){1'b0}}, LEN_SAT}) ?
                                          LEN_SAT : len_full[LEN_W-1:0];
                  end
               end
            end
            PH_PAYLOAD: begin
               xor_in             = xor_ff ^ rx_byte;
               cnt_in             = cnt_inc;
               res_valid          = 1'b1;
               res.data_byte      = rx_byte;
               res.payload_length = len_sat;
            end
            PH_XOR: csum_ok_in = xor_match;
            PH_END: begin
               res_valid          = 1'b1;
               res.last           = 1'b1;
               res.payload_length = len_sat;
               if (!is_end)          res.event_res = EV_END_ERR;
               else if (!csum_ok_ff) res.event_res = EV_REQ_CSUM;
               else                  res.event_res = EV_REQ_OK;
            end
            PH_ACK: begin
               case (cnt_ff[1:0])
                  2'd0: begin
                     param_in = rx_byte;
                     xor_in   = xor_ff ^ rx_byte;
                     cnt_in   = LEN_W'(1);
                  end
                  2'd1: begin
                     code_lo_in = rx_byte;
                     xor_in     = xor_ff ^ rx_byte;
                     cnt_in     = LEN_W'(2);
                  end
                  2'd2: begin
                     csum_ok_in = xor_match;
                     cnt_in     = LEN_W'(3);
                  end
                  default: begin
                     cnt_in        = '0;
                     res_valid     = 1'b1;
                     res.last      = 1'b1;
                     res.data_byte = code_lo_ff;
                     res.event_res = (is_end && csum_ok_ff) ? EV_ACK_OK : EV_ACK_ERR;
                  end
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         cnt_ff     <= '0;
         xor_ff     <= '0;
         type_ff    <= '0;
         param_ff   <= '0;
         len_ff     <= '0;
         code_lo_ff <= '0;
         csum_ok_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         xor_ff     <= xor_in;
         type_ff    <= type_in;
         param_ff   <= param_in;
         len_ff     <= len_in;
         code_lo_ff <= code_lo_in;
         csum_ok_ff <= csum_ok_in;
      end
   end

endmodule

/* sv/dfpx_obuf.sv */
// Result register with skid stage.
module dfpx_obuf import dfpx_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    push_ready,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_ready
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;

   assign push_ready = !skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_data   = out_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (out_valid_ff && !out_ready) begin
         // output stalled: a new word parks in the skid stage
         if (push) begin
            skid_valid_in = 1'b1;
            skid_in       = push_data;
         end
      end else if (skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_in        = skid_ff;
         skid_valid_in = push;
         skid_in       = push_data;
      end else begin
         out_valid_in = push;
         out_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

/* sv/delimited_frame_parser_xor.sv */
// Result words are registered, in the result register or the skid word if rsp stalls.
// Throughput: one byte per cycle while the skid word is empty; input stalls when full.
// A result register plus one skid word let input continue while rsp is stalled.
// Synchronous active-high reset returns the parser to hunting, empties the output
// stages and loads the configuration registers with their default values.
module delimited_frame_parser_xor import dfpx_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   dfpx_req_if.sink          req_chan,
   dfpx_rsp_if.source        rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type cfg;
   logic    in_fire;
   logic    res_valid;
   logic    push_ready;
   rsp_type res;
   rsp_type out_data;

   assign req_chan.ready = push_ready;
   assign in_fire        = req_chan.valid && push_ready;

   dfpx_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   dfpx_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_fire   (in_fire),
      .rx_byte   (req_chan.rx_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   dfpx_obuf u_obuf (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res),
      .push_ready (push_ready),
      .out_valid  (rsp_chan.valid),
      .out_data   (out_data),
      .out_ready  (rsp_chan.ready)
   );

   assign rsp_chan.event_res      = out_data.event_res;
   assign rsp_chan.data_byte      = out_data.data_byte;
   assign rsp_chan.frame_type     = out_data.frame_type;
   assign rsp_chan.frame_param    = out_data.frame_param;
   assign rsp_chan.payload_length = out_data.payload_length;
   assign rsp_chan.last           = out_data.last;

endmodule
